/* rtl/cfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes of the contiguous fit allocator: transfer structs,
// table entry layout, operation, policy and status codes, sequencer states.
// ----------------------------------------------------------------------------
package cfa_pkg;

  typedef logic [15:0] addr_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  fit_policy;
    logic [15:0] request_size;
    logic [5:0]  release_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_start;
    logic [5:0]  block_slot;
    logic [15:0] free_total;
    logic [6:0]  hole_total;
    logic        fragmented;
  } out_item_t;

  // one entry of the hole table or the block table
  typedef struct packed {
    addr_t start;
    addr_t len;
  } seg_t;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_REPORT  = 2'd2;
  localparam logic [1:0] FN_INIT    = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [1:0] STAT_NO_SLOT = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  localparam addr_t       POOL_BASE_RST = 16'd100;
  localparam addr_t       POOL_SIZE_RST = 16'd900;
  localparam logic [16:0] ADDR_SPAN     = 17'h10000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_UPD,
    S_R_BRD,
    S_R_SCAN,
    S_R_DEC,
    S_H_SHUP,
    S_H_INS,
    S_H_SHDN,
    S_B_START,
    S_B_SHDN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/cfa_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_ram
// Simple dual-port synchronous table: one write port, one registered read.
// ----------------------------------------------------------------------------
module cfa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/contiguous_fit_allocator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_core
// Hole-list allocator: address-ordered hole table and compacted block table,
// both in synchronous memories, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage: raise start with a command on in_data while busy is low; the command
// is taken at that edge and busy stays high until the result has gone out.
// The result appears on out_data for exactly one cycle with out_strobe high.
// Configuration (pool_base, pool_size) is written through cfg_we/cfg_idx/
// cfg_wdata; the user writes it only while the block is idle, which the
// block itself does not enforce. It takes effect on the next initialize.
// Each table has a single read port, and a pass reads one entry a cycle:
//   report, initialize and rejected commands: go straight to the result
//   allocate: scan all holes, update; shift later holes down if one is used up
//   release:  read the block, scan holes up to its address, merge or insert
//             (shifting later holes), then shift later blocks down
// The next command is taken once the block is back in idle after the result.
// Worst case is about two passes over a table.
// After reset both tables are empty and the pool registers hold 100 and 900;
// no clearing pass is needed. The receiver cannot stall: a result is shown
// once and the block returns to idle the cycle after.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator_core #(
  parameter int HOLE_SLOTS  = 64,
  parameter int BLOCK_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire cfa_pkg::in_item_t  in_data,
  output logic                    out_strobe,
  output cfa_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [15:0]        cfg_wdata
);
  import cfa_pkg::*;

  localparam int HI_W = $clog2(HOLE_SLOTS);
  localparam int HC_W = $clog2(HOLE_SLOTS + 1);
  localparam int BI_W = $clog2(BLOCK_SLOTS);
  localparam int BC_W = $clog2(BLOCK_SLOTS + 1);
  localparam int PW   = (HC_W > BC_W) ? HC_W : BC_W;
  localparam int CW   = (BC_W > 6) ? BC_W : 6;
  localparam int TW   = (HC_W > 7) ? HC_W : 7;

  state_t state_r, state_nxt;

  addr_t pool_base_r, pool_size_r;
  logic [HC_W-1:0] hole_used_r, hole_used_nxt;
  logic [BC_W-1:0] block_used_r, block_used_nxt;
  addr_t free_r, free_nxt;

  logic [1:0]  op_r, op_nxt;
  logic [1:0]  pol_r, pol_nxt;
  addr_t       size_r, size_nxt;
  logic [BC_W-1:0] rel_slot_r, rel_slot_nxt;

  logic [PW-1:0] ptr_r, ptr_nxt, last_r, last_nxt, idx_r, idx_nxt;
  logic          more_r, more_nxt, vld_r, vld_nxt;

  logic            found_r, found_nxt;
  logic [HI_W-1:0] pick_idx_r, pick_idx_nxt;
  seg_t            pick_r, pick_nxt;

  seg_t            bs_r, bs_nxt, prev_r, prev_nxt, next_r, next_nxt;
  logic            prev_vld_r, prev_vld_nxt, next_vld_r, next_vld_nxt;
  logic [HI_W-1:0] prev_idx_r, prev_idx_nxt;
  logic [HC_W-1:0] pos_r, pos_nxt;

  logic [1:0] status_r, status_nxt;
  addr_t      start_r, start_nxt;
  logic [5:0] bslot_r, bslot_nxt;

  logic            h_we, b_we;
  logic [HI_W-1:0] h_waddr, h_raddr;
  logic [BI_W-1:0] b_waddr, b_raddr;
  seg_t            h_wdata, h_rdata, b_wdata, b_rdata;

  // shared decisions
  logic          acc, pass_end, issue, a_reject, rel_bad;
  logic          left, right, hfull, drop_tail_a, drop_tail_r, bshift;
  logic          scan_lower, pos_lt;
  logic [CW-1:0] slot_ext;
  logic [PW-1:0] hole_last, block_last;
  logic [16:0]   pool_sum;
  addr_t         pool_len, newlen;
  logic [TW-1:0] hu_ext;
  logic [CW-1:0] bu_ext;

  cfa_ram #(.DEPTH(HOLE_SLOTS), .WIDTH($bits(seg_t))) u_hole_ram (
    .clk(clk), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
    .rd_addr(h_raddr), .rd_data(h_rdata)
  );

  cfa_ram #(.DEPTH(BLOCK_SLOTS), .WIDTH($bits(seg_t))) u_block_ram (
    .clk(clk), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
    .rd_addr(b_raddr), .rd_data(b_rdata)
  );

  assign acc        = start && (state_r == S_IDLE);
  assign pass_end   = vld_r && (idx_r == last_r);
  assign issue      = more_r && ((state_r == S_A_SCAN) || (state_r == S_R_SCAN) ||
                                 (state_r == S_H_SHUP) || (state_r == S_H_SHDN) ||
                                 (state_r == S_B_SHDN));
  assign slot_ext   = CW'(in_data.release_slot);
  assign hole_last  = PW'(hole_used_r) - PW'(1);
  assign block_last = PW'(block_used_r) - PW'(1);
  assign a_reject   = (in_data.request_size == '0) ||
                      (block_used_r >= BC_W'(BLOCK_SLOTS)) || (hole_used_r == '0);
  assign rel_bad    = slot_ext >= CW'(block_used_r);
  assign left       = prev_vld_r &&
                      (({1'b0, prev_r.start} + {1'b0, prev_r.len}) == {1'b0, bs_r.start});
  assign right      = next_vld_r &&
                      (({1'b0, bs_r.start} + {1'b0, bs_r.len}) == {1'b0, next_r.start});
  assign hfull      = hole_used_r >= HC_W'(HOLE_SLOTS);
  assign drop_tail_a = (PW'(pick_idx_r) + PW'(1)) < PW'(hole_used_r);
  assign drop_tail_r = (PW'(pos_r) + PW'(1)) < PW'(hole_used_r);
  assign bshift     = (PW'(rel_slot_r) + PW'(1)) < PW'(block_used_r);
  assign scan_lower = h_rdata.start <= bs_r.start;
  assign pos_lt     = PW'(pos_r) < PW'(hole_used_r);
  assign newlen     = pick_r.len - size_r;
  assign pool_sum   = {1'b0, pool_base_r} + {1'b0, pool_size_r};
  assign pool_len   = (pool_sum > ADDR_SPAN) ? 16'(ADDR_SPAN - {1'b0, pool_base_r})
                                             : pool_size_r;
  assign bu_ext     = CW'(block_used_r);

  assign h_raddr = ptr_r[HI_W-1:0];
  assign b_raddr = (state_r == S_IDLE) ? slot_ext[BI_W-1:0] : ptr_r[BI_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_data.func)
            FN_ALLOC:   state_nxt = a_reject ? S_DONE : S_A_SCAN;
            FN_RELEASE: state_nxt = rel_bad ? S_DONE : S_R_BRD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_A_SCAN: if (pass_end) state_nxt = S_A_UPD;
      S_A_UPD: begin
        if (found_r && (newlen == '0) && drop_tail_a) state_nxt = S_H_SHDN;
        else state_nxt = S_DONE;
      end
      S_R_BRD:  state_nxt = (hole_used_r == '0) ? S_R_DEC : S_R_SCAN;
      S_R_SCAN: if (vld_r && (!scan_lower || pass_end)) state_nxt = S_R_DEC;
      S_R_DEC: begin
        if (left) state_nxt = (right && drop_tail_r) ? S_H_SHDN : S_B_START;
        else if (right) state_nxt = S_B_START;
        else if (hfull) state_nxt = S_DONE;
        else state_nxt = pos_lt ? S_H_SHUP : S_H_INS;
      end
      S_H_SHUP:  if (pass_end) state_nxt = S_H_INS;
      S_H_INS:   state_nxt = S_B_START;
      S_H_SHDN: begin
        if (pass_end) state_nxt = (op_r == FN_RELEASE) ? S_B_START : S_DONE;
      end
      S_B_START: state_nxt = bshift ? S_B_SHDN : S_DONE;
      S_B_SHDN:  if (pass_end) state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath, table ports and result
  always_comb begin
    hole_used_nxt  = hole_used_r;
    block_used_nxt = block_used_r;
    free_nxt       = free_r;
    op_nxt         = op_r;
    pol_nxt        = pol_r;
    size_nxt       = size_r;
    rel_slot_nxt   = rel_slot_r;
    ptr_nxt        = ptr_r;
    last_nxt       = last_r;
    idx_nxt        = idx_r;
    more_nxt       = more_r;
    vld_nxt        = 1'b0;
    found_nxt      = found_r;
    pick_idx_nxt   = pick_idx_r;
    pick_nxt       = pick_r;
    bs_nxt         = bs_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    prev_vld_nxt   = prev_vld_r;
    next_vld_nxt   = next_vld_r;
    prev_idx_nxt   = prev_idx_r;
    pos_nxt        = pos_r;
    status_nxt     = status_r;
    start_nxt      = start_r;
    bslot_nxt      = bslot_r;
    h_we           = 1'b0;
    h_waddr        = '0;
    h_wdata        = '0;
    b_we           = 1'b0;
    b_waddr        = '0;
    b_wdata        = '0;

    // one table read per cycle while a pass runs
    if (issue) begin
      vld_nxt = 1'b1;
      idx_nxt = ptr_r;
      if (ptr_r == last_r) more_nxt = 1'b0;
      else if (state_r == S_H_SHUP) ptr_nxt = ptr_r - PW'(1);
      else ptr_nxt = ptr_r + PW'(1);
    end

    case (state_r)
      S_IDLE: begin
        more_nxt = 1'b0;
        if (acc) begin
          op_nxt       = in_data.func;
          pol_nxt      = in_data.fit_policy;
          size_nxt     = in_data.request_size;
          rel_slot_nxt = slot_ext[BC_W-1:0];
          status_nxt   = STAT_OK;
          start_nxt    = '0;
          bslot_nxt    = '0;
          case (in_data.func)
            FN_ALLOC: begin
              if (in_data.request_size == '0) status_nxt = STAT_NO_FIT;
              else if (block_used_r >= BC_W'(BLOCK_SLOTS)) status_nxt = STAT_FULL;
              else if (hole_used_r == '0) status_nxt = STAT_NO_FIT;
              else begin
                found_nxt = 1'b0;
                ptr_nxt   = '0;
                last_nxt  = hole_last;
                more_nxt  = 1'b1;
              end
            end
            FN_RELEASE: begin
              if (rel_bad) status_nxt = STAT_NO_SLOT;
            end
            FN_INIT: begin
              block_used_nxt = '0;
              if (pool_len != '0) begin
                h_we          = 1'b1;
                h_waddr       = '0;
                h_wdata       = '{start: pool_base_r, len: pool_len};
                hole_used_nxt = HC_W'(1);
                free_nxt      = pool_len;
              end else begin
                hole_used_nxt = '0;
                free_nxt      = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_A_SCAN: begin
        if (vld_r && (h_rdata.len >= size_r)) begin
          if (!found_r ||
              ((pol_r == POL_BEST) && (h_rdata.len < pick_r.len)) ||
              ((pol_r == POL_WORST) && (h_rdata.len > pick_r.len))) begin
            if (!found_r || (pol_r == POL_BEST) || (pol_r == POL_WORST)) begin
              found_nxt    = 1'b1;
              pick_idx_nxt = idx_r[HI_W-1:0];
              pick_nxt     = h_rdata;
            end
          end
        end
      end
      S_A_UPD: begin
        if (!found_r) begin
          status_nxt = STAT_NO_FIT;
        end else begin
          b_we           = 1'b1;
          b_waddr        = block_used_r[BI_W-1:0];
          b_wdata        = '{start: pick_r.start, len: size_r};
          bslot_nxt      = bu_ext[5:0];
          block_used_nxt = block_used_r + BC_W'(1);
          start_nxt      = pick_r.start;
          free_nxt       = free_r - size_r;
          if (newlen != '0) begin
            h_we    = 1'b1;
            h_waddr = pick_idx_r;
            h_wdata = '{start: pick_r.start + size_r, len: newlen};
          end else if (drop_tail_a) begin
            ptr_nxt  = PW'(pick_idx_r) + PW'(1);
            last_nxt = hole_last;
            more_nxt = 1'b1;
          end else begin
            hole_used_nxt = hole_used_r - HC_W'(1);
          end
        end
      end
      S_R_BRD: begin
        bs_nxt       = b_rdata;
        prev_vld_nxt = 1'b0;
        next_vld_nxt = 1'b0;
        pos_nxt      = '0;
        ptr_nxt      = '0;
        last_nxt     = hole_last;
        more_nxt     = (hole_used_r != '0);
      end
      S_R_SCAN: begin
        if (vld_r) begin
          if (scan_lower) begin
            prev_nxt     = h_rdata;
            prev_vld_nxt = 1'b1;
            prev_idx_nxt = idx_r[HI_W-1:0];
            if (pass_end) pos_nxt = hole_used_r;
          end else begin
            pos_nxt      = HC_W'(idx_r);
            next_nxt     = h_rdata;
            next_vld_nxt = 1'b1;
          end
        end
      end
      S_R_DEC: begin
        more_nxt = 1'b0;
        if (left) begin
          h_we    = 1'b1;
          h_waddr = prev_idx_r;
          h_wdata = '{start: prev_r.start,
                      len: prev_r.len + bs_r.len + (right ? next_r.len : '0)};
          if (right) begin
            if (drop_tail_r) begin
              ptr_nxt  = PW'(pos_r) + PW'(1);
              last_nxt = hole_last;
              more_nxt = 1'b1;
            end else begin
              hole_used_nxt = hole_used_r - HC_W'(1);
            end
          end
        end else if (right) begin
          h_we    = 1'b1;
          h_waddr = pos_r[HI_W-1:0];
          h_wdata = '{start: bs_r.start, len: next_r.len + bs_r.len};
        end else if (hfull) begin
          status_nxt = STAT_FULL;
        end else if (pos_lt) begin
          ptr_nxt  = hole_last;
          last_nxt = PW'(pos_r);
          more_nxt = 1'b1;
        end
      end
      S_H_SHUP: begin
        if (vld_r) begin
          h_we    = 1'b1;
          h_waddr = idx_r[HI_W-1:0] + HI_W'(1);
          h_wdata = h_rdata;
        end
      end
      S_H_INS: begin
        h_we          = 1'b1;
        h_waddr       = pos_r[HI_W-1:0];
        h_wdata       = bs_r;
        hole_used_nxt = hole_used_r + HC_W'(1);
      end
      S_H_SHDN: begin
        if (vld_r) begin
          h_we    = 1'b1;
          h_waddr = idx_r[HI_W-1:0] - HI_W'(1);
          h_wdata = h_rdata;
        end
        if (pass_end) hole_used_nxt = hole_used_r - HC_W'(1);
      end
      S_B_START: begin
        free_nxt  = free_r + bs_r.len;
        start_nxt = bs_r.start;
        if (bshift) begin
          ptr_nxt  = PW'(rel_slot_r) + PW'(1);
          last_nxt = block_last;
          more_nxt = 1'b1;
        end else begin
          block_used_nxt = block_used_r - BC_W'(1);
        end
      end
      S_B_SHDN: begin
        if (vld_r) begin
          b_we    = 1'b1;
          b_waddr = idx_r[BI_W-1:0] - BI_W'(1);
          b_wdata = b_rdata;
        end
        if (pass_end) block_used_nxt = block_used_r - BC_W'(1);
      end
      default: more_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pool_base_r  <= POOL_BASE_RST;
      pool_size_r  <= POOL_SIZE_RST;
      hole_used_r  <= '0;
      block_used_r <= '0;
      free_r       <= '0;
      more_r       <= 1'b0;
      vld_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hole_used_r  <= hole_used_nxt;
      block_used_r <= block_used_nxt;
      free_r       <= free_nxt;
      more_r       <= more_nxt;
      vld_r        <= vld_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_POOL_BASE: pool_base_r <= cfg_wdata;
          CFG_POOL_SIZE: pool_size_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pol_r      <= pol_nxt;
    size_r     <= size_nxt;
    rel_slot_r <= rel_slot_nxt;
    ptr_r      <= ptr_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_r     <= pick_nxt;
    bs_r       <= bs_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    prev_vld_r <= prev_vld_nxt;
    next_vld_r <= next_vld_nxt;
    prev_idx_r <= prev_idx_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
    bslot_r    <= bslot_nxt;
  end

  assign hu_ext     = TW'(hole_used_r);
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  always_comb begin
    out_data.status      = status_r;
    out_data.block_start = start_r;
    out_data.block_slot  = bslot_r;
    out_data.free_total  = free_r;
    out_data.hole_total  = hu_ext[6:0];
    out_data.fragmented  = hole_used_r > HC_W'(1);
  end

endmodule
`default_nettype wire

/* rtl/cfa_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the allocator's command and result behaviour.
// ----------------------------------------------------------------------------
module cfa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire cfa_pkg::out_item_t out_data
);
  import cfa_pkg::*;

  // a result only shows while a command is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result outside a command");

  // an accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command not taken");

  // after its result the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!busy && !out_strobe)) else $error("block stuck after result");

  // fragmented flag follows the hole count
  a_frag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.fragmented == (out_data.hole_total > 7'd1)))
    else $error("fragmented flag wrong");

endmodule

bind contiguous_fit_allocator_core cfa_checker u_cfa_checker (.*);
`default_nettype wire
